[rtl/table_row_condition_filter_core_defines.svh]
// ----------------------------------------------------------------------------
// Table row condition filter: assertion macros
// Shared property shorthands for the checker of the filter core.
// ----------------------------------------------------------------------------
`ifndef TABLE_ROW_CONDITION_FILTER_CORE_DEFINES_SVH
`define TABLE_ROW_CONDITION_FILTER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define TRCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TRCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/trcf_pkg.sv]
// ----------------------------------------------------------------------------
// trcf_pkg
// Field widths, request codes and sequencer states of the row filter.
// ----------------------------------------------------------------------------
package trcf_pkg;

    localparam int REQ_W   = 1;
    localparam int ROW_IN_W = 10;
    localparam int COL_W   = 5;
    localparam int VAL_W   = 8;
    localparam int NCOND_W = 3;
    localparam int MASK_W  = 64;
    localparam int WORD_W  = 6;
    localparam int COUNT_W = 11;
    localparam int SLOT_W  = 6;     // row offset inside one mask word
    localparam int NUM_PORT_CONDS = 4;

    localparam logic [REQ_W-1:0] REQ_WRITE = 1'b0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage

[rtl/trcf_ram.sv]
// ----------------------------------------------------------------------------
// trcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/table_row_condition_filter_core.sv]
// ----------------------------------------------------------------------------
// table_row_condition_filter_core
// Cell table with a conjunctive equality scan, results as 64-row bitmaps.
// ----------------------------------------------------------------------------
// A write item stores one cell and gives no result. A query is worked by one
// shared equality comparator fed from the single read port of the cell RAM,
// one (row, condition) pair at a time. After the reads of each 64-row word the
// sequencer drains the compare stage and then emits the word, waiting out any
// stall on the result side. The input is stalled for the whole query. A
// query with no rows in use goes straight to the emit state and presents a
// single empty last word.
module table_row_condition_filter_core
    import trcf_pkg::*;
#(
    parameter int ROWS           = 1024,
    parameter int COLUMNS        = 32,
    parameter int STATE_BITS     = 8,
    parameter int MAX_CONDITIONS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [ROW_IN_W-1:0] i_row,
    input  logic [COL_W-1:0]   i_column,
    input  logic [VAL_W-1:0]   i_value,
    input  logic [NCOND_W-1:0] i_num_conditions,
    input  logic [COL_W-1:0]   i_second_column,
    input  logic [VAL_W-1:0]   i_second_value,
    input  logic [COL_W-1:0]   i_third_column,
    input  logic [VAL_W-1:0]   i_third_value,
    input  logic [COL_W-1:0]   i_fourth_column,
    input  logic [VAL_W-1:0]   i_fourth_value,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [MASK_W-1:0]  o_match_mask,
    output logic [WORD_W-1:0]  o_word_index,
    output logic [COUNT_W-1:0] o_match_count,
    output logic               o_last
);

    localparam int ADDR_W = $clog2(ROWS * COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int K_W    = (MAX_CONDITIONS > 1) ? $clog2(MAX_CONDITIONS) : 1;
    localparam int CMP_W  = (STATE_BITS > VAL_W) ? STATE_BITS : VAL_W;

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_rows_in_use;

    // query context
    logic [COL_W-1:0]          r_col [MAX_CONDITIONS];
    logic [VAL_W-1:0]          r_val [MAX_CONDITIONS];
    logic [MAX_CONDITIONS-1:0] r_col_ok;
    logic [K_W-1:0]            r_k_last;
    logic                      r_no_cond;
    logic [ROW_W-1:0]          r_scan;

    // scan position
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_base;
    logic [K_W-1:0]    r_k;

    // compare stage tag, registered with the read address to line up with the read data
    logic              r_t_valid;
    logic              r_t_first;
    logic              r_t_last;
    logic              r_t_no_cond;
    logic              r_t_col_ok;
    logic [VAL_W-1:0]  r_t_val;
    logic [SLOT_W-1:0] r_t_slot;
    logic              r_row_ok;

    // word accumulation
    logic [MASK_W-1:0]  r_mask;
    logic [COUNT_W-1:0] r_count;
    logic [WORD_W-1:0]  r_word;
    logic               r_last_word;

    // output register
    logic               r_out_valid;
    logic [MASK_W-1:0]  r_out_mask;
    logic [WORD_W-1:0]  r_out_word;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_last;

    // decoded controls
    logic in_take, take_write, take_query, issue, emit, out_free;
    logic row_done, word_end, final_row;

    logic [COL_W-1:0]   in_col [NUM_PORT_CONDS];
    logic [VAL_W-1:0]   in_val [NUM_PORT_CONDS];
    logic [NCOND_W-1:0] n_sat;
    logic [K_W-1:0]     k_last;
    logic [ROW_W-1:0]   scan_sat;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [STATE_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [STATE_BITS-1:0] mem_rdata;

    logic hit, acc;

    assign in_col[0] = i_column;
    assign in_col[1] = i_second_column;
    assign in_col[2] = i_third_column;
    assign in_col[3] = i_fourth_column;
    assign in_val[0] = i_value;
    assign in_val[1] = i_second_value;
    assign in_val[2] = i_third_value;
    assign in_val[3] = i_fourth_value;

    assign n_sat = (32'(i_num_conditions) > MAX_CONDITIONS) ?
                   NCOND_W'(MAX_CONDITIONS) : i_num_conditions;
    assign k_last = (n_sat == '0) ? '0 : K_W'(n_sat - 1'b1);
    assign scan_sat = (32'(r_rows_in_use) > ROWS) ? ROW_W'(ROWS) : ROW_W'(r_rows_in_use);

    assign out_free  = !r_out_valid || !i_out_stall;
    assign row_done  = (r_k == r_k_last);
    assign final_row = (ROW_W'(r_row + 1'b1) == r_scan);
    assign word_end  = row_done && (final_row || (r_row[SLOT_W-1:0] == '1));

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_req_type == REQ_QUERY)) begin
                    n_state = (scan_sat == '0) ? S_EMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (word_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = r_last_word ? S_IDLE : S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        in_take    = 1'b0;
        issue      = 1'b0;
        emit       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                in_take    = i_in_valid;
            end
            S_SCAN: begin
                issue = 1'b1;
            end
            S_DRAIN: begin
                issue = 1'b0;
            end
            S_EMIT: begin
                emit = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign take_write = in_take && (i_req_type == REQ_WRITE);
    assign take_query = in_take && (i_req_type == REQ_QUERY);

    // ------------------------------------------------------------------------
    // Cell RAM
    // ------------------------------------------------------------------------
    assign mem_we    = take_write && (32'(i_row) < ROWS) && (32'(i_column) < COLUMNS);
    assign mem_waddr = ADDR_W'(ADDR_W'(i_row) * ADDR_W'(COLUMNS)) + ADDR_W'(i_column);
    assign mem_wdata = STATE_BITS'(i_value);
    assign mem_raddr = r_base + ADDR_W'(r_col[r_k]);

    trcf_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (ROWS * COLUMNS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // shared comparator: one condition of one row per cycle while the sequencer scans
    assign hit = r_t_no_cond ||
                 (r_t_col_ok && (CMP_W'(mem_rdata) == CMP_W'(r_t_val)));
    assign acc = (r_t_first || r_row_ok) && hit;

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rows_in_use <= '0;
            r_t_valid     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_t_valid <= issue;
            if (i_cfg_we) begin
                r_rows_in_use <= i_cfg_wdata;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (take_query) begin
            for (int k = 0; k < MAX_CONDITIONS; k++) begin
                r_col[k]    <= in_col[k];
                r_val[k]    <= in_val[k];
                r_col_ok[k] <= (32'(in_col[k]) < COLUMNS);
            end
            r_k_last    <= k_last;
            r_no_cond   <= (n_sat == '0);
            r_scan      <= scan_sat;
            r_row       <= '0;
            r_base      <= '0;
            r_k         <= '0;
            r_mask      <= '0;
            r_count     <= '0;
            r_word      <= '0;
            r_last_word <= (scan_sat == '0);
        end

        // advance the read address
        if (issue) begin
            r_t_first   <= (r_k == '0);
            r_t_last    <= row_done;
            r_t_no_cond <= r_no_cond;
            r_t_col_ok  <= r_col_ok[r_k];
            r_t_val     <= r_val[r_k];
            r_t_slot    <= r_row[SLOT_W-1:0];
            if (row_done) begin
                r_k    <= '0;
                r_row  <= ROW_W'(r_row + 1'b1);
                r_base <= r_base + ADDR_W'(COLUMNS);
            end else begin
                r_k <= K_W'(r_k + 1'b1);
            end
            if (word_end) begin
                r_last_word <= final_row;
            end
        end

        // fold one condition into the row result
        if (r_t_valid) begin
            if (r_t_last) begin
                if (acc) begin
                    r_mask[r_t_slot] <= 1'b1;
                    r_count          <= COUNT_W'(r_count + 1'b1);
                end
            end else begin
                r_row_ok <= acc;
            end
        end

        // hand the finished word over and start the next one
        if (emit) begin
            r_out_mask  <= r_mask;
            r_out_word  <= r_word;
            r_out_count <= r_last_word ? r_count : '0;
            r_out_last  <= r_last_word;
            r_mask      <= '0;
            r_word      <= WORD_W'(r_word + 1'b1);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_mask  = r_out_mask;
    assign o_word_index  = r_out_word;
    assign o_match_count = r_out_count;
    assign o_last        = r_out_last;

endmodule

[rtl/trcf_checker.sv]
// ----------------------------------------------------------------------------
// trcf_checker
// Port-level checks on the row filter core, bound to the top level.
// ----------------------------------------------------------------------------
`include "table_row_condition_filter_core_defines.svh"

module trcf_checker
    import trcf_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_stall,
    input logic [REQ_W-1:0]   i_req_type,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input logic [MASK_W-1:0]  i_match_mask,
    input logic [WORD_W-1:0]  i_word_index,
    input logic [COUNT_W-1:0] i_match_count,
    input logic               i_last
);

    // a stalled result word holds
    `TRCF_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_match_mask) && $stable(i_word_index) && $stable(i_match_count) && $stable(i_last), "stalled result word changed")

    `TRCF_ASSERT_SAME(a_count_on_last, i_out_valid && !i_last, i_match_count == '0, "match count set on a word that is not last")

    // a query transfer is followed by a stalled input (the core holds it until the last word is produced)
    `TRCF_ASSERT_NEXT(a_query_busy, i_in_valid && !i_in_stall && (i_req_type == REQ_QUERY), i_in_stall, "input not stalled after query transfer")

    `TRCF_ASSERT_SAME(a_mid_query_busy, i_out_valid && !i_last, i_in_stall, "input open while a query is unfinished")

endmodule

bind table_row_condition_filter_core trcf_checker u_trcf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .i_in_stall    (o_in_stall),
    .i_req_type    (i_req_type),
    .i_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .i_match_mask  (o_match_mask),
    .i_word_index  (o_word_index),
    .i_match_count (o_match_count),
    .i_last        (o_last)
);
